[sv/assert_macros.svh]
// Assertion macros used by the checker module of the block.
// Depends on nothing; included by files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check at every rising clock edge, off while reset is held.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/rrsp_pkg.sv]
// Types, codes and digit helpers of the retro RTC bus and serial port unit.
// Depends on nothing; used by rrsp_core, the top level and the bench.
package rrsp_pkg;

  localparam int unsigned ByteCount  = 8;
  localparam int unsigned DigitCount = 18;
  localparam int unsigned IdxW       = $clog2(DigitCount);

  localparam logic [1:0] ACT_BUS_READ  = 2'd0;
  localparam logic [1:0] ACT_SER_WRITE = 2'd1;
  localparam logic [1:0] ACT_SER_READ  = 2'd2;

  localparam logic [7:0] PORT_DATA  = 8'd0;
  localparam logic [7:0] PORT_LATCH = 8'd1;

  localparam logic [2:0] CTL_SELECT = 3'd5;
  localparam logic [2:0] CTL_CLOCK  = 3'd6;
  localparam logic [2:0] CTL_DATA   = 3'd7;

  localparam logic [7:0] LATCH_ID    = 8'hD2;
  localparam logic [7:0] IDLE_BYTE   = 8'hFF;
  localparam logic [6:0] LOW_ONES    = 7'h7F;
  localparam logic [3:0] FILL_DIGIT  = 4'hF;
  localparam logic [6:0] BIT_LIMIT   = 7'd72;
  localparam logic [6:0] BIT_JUMP    = 7'd5;
  localparam logic [6:0] BIT_RESTART = 7'd8;
  localparam logic [6:0] CMD_LIMIT   = 7'd4;

  typedef struct packed {
    logic [5:0] now_fraction;
    logic [5:0] now_second;
    logic [5:0] now_minute;
    logic [4:0] now_hour;
    logic [4:0] now_day;
    logic [3:0] now_month;
    logic [6:0] now_year;
    logic [6:0] now_century;
    logic [7:0] value;
    logic [7:0] port;
    logic [1:0] action;
  } item_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } result_t;

  function automatic logic [3:0] tens_f(input logic [6:0] v);
    logic [17:0] prod;
    prod = 18'(v) * 18'd205;
    return prod[14:11];
  endfunction

  function automatic logic [3:0] units_f(input logic [6:0] v);
    logic [6:0] t10;
    logic [6:0] rem;
    t10 = 7'(tens_f(v)) * 7'd10;
    rem = v - t10;
    return rem[3:0];
  endfunction

endpackage

[sv/rrsp_core.sv]
// Time latch, bus-clock and serial-chip state, and per-item result logic.
// Depends on rrsp_pkg.
module rrsp_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  rrsp_pkg::item_t    item_i,
  output rrsp_pkg::result_t  res_o
);

  logic [6:0] latched_q [rrsp_pkg::ByteCount];
  logic [6:0] latched_d [rrsp_pkg::ByteCount];
  logic [3:0] digit_q   [rrsp_pkg::DigitCount];
  logic [3:0] digit_d   [rrsp_pkg::DigitCount];
  logic [2:0] rd_ptr_q, rd_ptr_d;
  logic [7:0] ctl_q, ctl_d;
  logic [6:0] bit_ptr_q, bit_ptr_d;
  logic [3:0] cmd_q, cmd_d;

  logic                     do_latch;
  logic [2:0]               sel;
  logic                     level;
  logic [6:0]               bp_inc;
  logic [6:0]               p;
  logic [rrsp_pkg::IdxW-1:0] idx;
  logic [3:0]               dsel;
  logic                     dbit;

  always_comb begin
    res_o     = '0;
    rd_ptr_d  = rd_ptr_q;
    ctl_d     = ctl_q;
    bit_ptr_d = bit_ptr_q;
    cmd_d     = cmd_q;
    do_latch  = 1'b0;
    sel       = item_i.value[2:0];
    level     = item_i.value[7];
    bp_inc    = bit_ptr_q + 7'd1;
    p         = bit_ptr_q ^ 7'd7;
    idx       = p[6:2];
    dsel      = (32'(idx) < rrsp_pkg::DigitCount) ? digit_q[idx] : 4'd0;
    dbit      = dsel[~p[1:0]];

    case (item_i.action)
      rrsp_pkg::ACT_BUS_READ: begin
        res_o.valid = 1'b1;
        if (item_i.port == rrsp_pkg::PORT_DATA) begin
          res_o.data = {1'b0, latched_q[rd_ptr_q]};
          rd_ptr_d   = rd_ptr_q + 3'd1;
        end else if (item_i.port == rrsp_pkg::PORT_LATCH) begin
          res_o.data = rrsp_pkg::LATCH_ID;
          do_latch   = 1'b1;
        end else begin
          res_o.data = rrsp_pkg::IDLE_BYTE;
        end
      end
      rrsp_pkg::ACT_SER_WRITE: begin
        if (!item_i.port[0]) begin
          ctl_d[sel] = level;
          case (sel)
            rrsp_pkg::CTL_SELECT: begin
              do_latch = !ctl_q[sel] && level;
            end
            rrsp_pkg::CTL_CLOCK: begin
              if (ctl_q[sel] && !level && ctl_q[rrsp_pkg::CTL_SELECT]) begin
                if (bp_inc == rrsp_pkg::BIT_JUMP) begin
                  bit_ptr_d = {1'b0, cmd_q[2:0], 3'b000} + rrsp_pkg::BIT_RESTART;
                end else if (bp_inc >= rrsp_pkg::BIT_LIMIT) begin
                  bit_ptr_d = rrsp_pkg::BIT_RESTART;
                end else begin
                  bit_ptr_d = bp_inc;
                end
              end
            end
            rrsp_pkg::CTL_DATA: begin
              if (bit_ptr_q < rrsp_pkg::CMD_LIMIT) begin
                cmd_d[bit_ptr_q[1:0]] = !level;
              end
            end
            default: begin
            end
          endcase
        end
      end
      rrsp_pkg::ACT_SER_READ: begin
        res_o.valid = 1'b1;
        if (item_i.port[0] && ctl_q[rrsp_pkg::CTL_SELECT]) begin
          res_o.data = {dbit & ctl_q[rrsp_pkg::CTL_DATA], rrsp_pkg::LOW_ONES};
        end else begin
          res_o.data = rrsp_pkg::IDLE_BYTE;
        end
      end
      default: begin
      end
    endcase

    latched_d = latched_q;
    digit_d   = digit_q;
    if (do_latch) begin
      latched_d[0] = item_i.now_century;
      latched_d[1] = item_i.now_year;
      latched_d[2] = 7'(item_i.now_month);
      latched_d[3] = 7'(item_i.now_day);
      latched_d[4] = 7'(item_i.now_hour);
      latched_d[5] = 7'(item_i.now_minute);
      latched_d[6] = 7'(item_i.now_second);
      latched_d[7] = 7'(item_i.now_fraction);
      for (int i = 0; i < rrsp_pkg::DigitCount; i++) begin
        digit_d[i] = rrsp_pkg::FILL_DIGIT;
      end
      digit_d[2]  = rrsp_pkg::tens_f(latched_d[4]);
      digit_d[3]  = rrsp_pkg::units_f(latched_d[4]);
      digit_d[4]  = rrsp_pkg::tens_f(latched_d[5]);
      digit_d[5]  = rrsp_pkg::units_f(latched_d[5]);
      digit_d[6]  = rrsp_pkg::tens_f(latched_d[3]);
      digit_d[7]  = rrsp_pkg::units_f(latched_d[3]);
      digit_d[8]  = rrsp_pkg::tens_f(latched_d[2]);
      digit_d[9]  = rrsp_pkg::units_f(latched_d[2]);
      digit_d[10] = rrsp_pkg::tens_f(latched_d[1]);
      digit_d[11] = rrsp_pkg::units_f(latched_d[1]);
      digit_d[14] = rrsp_pkg::tens_f(latched_d[6]);
      digit_d[15] = rrsp_pkg::units_f(latched_d[6]);
      rd_ptr_d  = '0;
      bit_ptr_d = '0;
      cmd_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latched_q <= '{default: '0};
      digit_q   <= '{default: '0};
      rd_ptr_q  <= '0;
      ctl_q     <= '0;
      bit_ptr_q <= '0;
      cmd_q     <= '0;
    end else if (fire_i) begin
      latched_q <= latched_d;
      digit_q   <= digit_d;
      rd_ptr_q  <= rd_ptr_d;
      ctl_q     <= ctl_d;
      bit_ptr_q <= bit_ptr_d;
      cmd_q     <= cmd_d;
    end
  end

endmodule

[sv/retro_rtc_bus_and_serial_port_unit.sv]
// Retro RTC with a bus-clock face and a serial-chip face sharing one time latch.
// Top level: input register, rrsp_core, output register. Depends on rrsp_pkg.
//
// Usage: each slave item carries an access (bus-clock read, serial write,
// serial read) together with the current calendar time. Reads return one
// byte on the master side; serial writes return nothing.
// Path: an item is registered in the input register at acceptance, and once it
// moves on, its byte is registered in the output register.
// Throughput: one item per cycle while no untaken byte stalls it; the state update
// for an item is a single pass through rrsp_core between the two registers.
// Stall: while the output register holds an untaken byte, the item behind it
// waits in the input register; an item without a result still moves on.
// s_axis_tready drops only when both registers are full.
// Reset: clears both valid flags, the latch, the digits and all pointers.
module retro_rtc_bus_and_serial_port_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // action[1:0] port[9:2] value[17:10] now_century[24:18] now_year[31:25]
  // now_month[35:32] now_day[40:36] now_hour[45:41] now_minute[51:46]
  // now_second[57:52] now_fraction[63:58]
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_data[7:0]
  output logic [7:0]  m_axis_tdata
);

  logic              in_valid_q;
  rrsp_pkg::item_t   in_item_q;
  logic              out_valid_q;
  logic [7:0]        out_data_q;
  rrsp_pkg::result_t res;
  logic              advance;

  assign advance       = in_valid_q && (!res.valid || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  rrsp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .item_i (in_item_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q <= rrsp_pkg::item_t'(s_axis_tdata);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res.valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.valid) begin
      out_data_q <= res.data;
    end
  end

endmodule

[sv/rrsp_checker.sv]
// Port-level checks of the retro RTC unit, bound to its top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module rrsp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [63:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata
);

  `ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> !m_axis_tvalid, "output valid in reset")
  `ASSERT_CLK(a_ready_when_free, clk_i, rst_ni,
              (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready, "input blocked with free output")
  `ASSERT_CLK(a_stall_hold, clk_i, rst_ni,
              m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata),
              "stalled item changed")
  `ASSERT_CLK(a_input_known, clk_i, rst_ni,
              s_axis_tvalid |-> !$isunknown(s_axis_tdata), "unknown input item")

endmodule

bind retro_rtc_bus_and_serial_port_unit rrsp_checker u_rrsp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[test/retro_rtc_bus_and_serial_port_unit_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for retro_rtc_bus_and_serial_port_unit: bus-clock and serial-chip
// accesses with random time stamps and random stalls, checked against a mirror of the clock.
// Depends on rrsp_pkg and the unit's RTL.
module retro_rtc_bus_and_serial_port_unit_test;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int unsigned ItemGoal    = 800;
  localparam int unsigned GapMax      = 12;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned ReportMax   = 10;

  class rtc_mirror;
    logic [6:0] latched [rrsp_pkg::ByteCount];
    logic [2:0] read_ptr;
    logic [7:0] ctl;
    logic [6:0] bit_ptr;
    logic [3:0] cmd;
    logic [3:0] digits [rrsp_pkg::DigitCount];
    logic [7:0] expected_bytes [$];
    int unsigned errors;
    int unsigned checked;
    int unsigned latches;
    int unsigned wraps;

    function new();
      foreach (latched[i]) latched[i] = '0;
      foreach (digits[i]) digits[i] = '0;
      read_ptr = '0;
      ctl      = '0;
      bit_ptr  = '0;
      cmd      = '0;
      errors   = 0;
      checked  = 0;
      latches  = 0;
      wraps    = 0;
    endfunction

    function void put_pair(int unsigned pos, logic [6:0] v);
      digits[pos]     = 4'(v / 10);
      digits[pos + 1] = 4'(v % 10);
    endfunction

    function void take_time(rrsp_pkg::item_t it);
      latched[0] = it.now_century;
      latched[1] = it.now_year;
      latched[2] = 7'(it.now_month);
      latched[3] = 7'(it.now_day);
      latched[4] = 7'(it.now_hour);
      latched[5] = 7'(it.now_minute);
      latched[6] = 7'(it.now_second);
      latched[7] = 7'(it.now_fraction);
      foreach (digits[i]) digits[i] = rrsp_pkg::FILL_DIGIT;
      put_pair(2, latched[4]);
      put_pair(4, latched[5]);
      put_pair(6, latched[3]);
      put_pair(8, latched[2]);
      put_pair(10, latched[1]);
      put_pair(14, latched[6]);
      read_ptr = '0;
      bit_ptr  = '0;
      cmd      = '0;
      latches++;
    endfunction

    function void note_item(rrsp_pkg::item_t it);
      logic [2:0]  sel;
      logic        lvl;
      logic [7:0]  old;
      int unsigned bp;
      logic [6:0]  p;
      logic [3:0]  d;
      logic        bit_out;
      case (it.action)
        rrsp_pkg::ACT_BUS_READ: begin
          if (it.port == rrsp_pkg::PORT_DATA) begin
            expected_bytes.push_back({1'b0, latched[read_ptr]});
            read_ptr++;
          end else if (it.port == rrsp_pkg::PORT_LATCH) begin
            take_time(it);
            expected_bytes.push_back(rrsp_pkg::LATCH_ID);
          end else begin
            expected_bytes.push_back(rrsp_pkg::IDLE_BYTE);
          end
        end
        rrsp_pkg::ACT_SER_WRITE: begin
          if (!it.port[0]) begin
            sel = it.value[2:0];
            lvl = it.value[7];
            old = ctl;
            ctl[sel] = lvl;
            if (sel == rrsp_pkg::CTL_SELECT && !old[sel] && lvl) begin
              take_time(it);
            end else if (sel == rrsp_pkg::CTL_CLOCK && old[sel] && !lvl &&
                         ctl[rrsp_pkg::CTL_SELECT]) begin
              bp = bit_ptr + 1;
              if (bp == rrsp_pkg::BIT_JUMP) begin
                bp = 8 * cmd[2:0] + rrsp_pkg::BIT_RESTART;
              end else if (bp >= rrsp_pkg::BIT_LIMIT) begin
                bp = rrsp_pkg::BIT_RESTART;
                wraps++;
              end
              bit_ptr = 7'(bp);
            end else if (sel == rrsp_pkg::CTL_DATA && bit_ptr < rrsp_pkg::CMD_LIMIT) begin
              cmd[bit_ptr[1:0]] = !lvl;
            end
          end
        end
        rrsp_pkg::ACT_SER_READ: begin
          if (it.port[0] && ctl[rrsp_pkg::CTL_SELECT]) begin
            p = bit_ptr ^ 7'd7;
            d = (p[6:2] < rrsp_pkg::DigitCount) ? digits[p[6:2]] : 4'd0;
            bit_out = d[3 - p[1:0]] & ctl[rrsp_pkg::CTL_DATA];
            expected_bytes.push_back({bit_out, rrsp_pkg::LOW_ONES});
          end else begin
            expected_bytes.push_back(rrsp_pkg::IDLE_BYTE);
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void check_byte(logic [7:0] got);
      logic [7:0] want;
      checked++;
      if (expected_bytes.size() == 0) begin
        errors++;
        if (errors <= ReportMax) $display("byte %0d: %h arrived with nothing due", checked, got);
      end else begin
        want = expected_bytes.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= ReportMax) begin
            $display("byte %0d: expected %h, got %h", checked, want, got);
          end
        end
      end
    endfunction

    function int unsigned pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;

  rtc_mirror   mirror = new();
  bit          calm = 1'b0;
  int unsigned sent_items = 0;
  int unsigned idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  retro_rtc_bus_and_serial_port_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  function automatic rrsp_pkg::item_t make_item(logic [1:0] act, logic [7:0] prt,
                                                logic [7:0] val);
    rrsp_pkg::item_t it;
    bit              wild;
    wild = ($urandom_range(0, 7) == 0);
    it.action       = act;
    it.port         = prt;
    it.value        = val;
    it.now_century  = wild ? 7'($urandom) : 7'($urandom_range(0, 99));
    it.now_year     = wild ? 7'($urandom) : 7'($urandom_range(0, 99));
    it.now_month    = wild ? 4'($urandom) : 4'($urandom_range(1, 12));
    it.now_day      = wild ? 5'($urandom) : 5'($urandom_range(1, 31));
    it.now_hour     = wild ? 5'($urandom) : 5'($urandom_range(0, 23));
    it.now_minute   = wild ? 6'($urandom) : 6'($urandom_range(0, 59));
    it.now_second   = wild ? 6'($urandom) : 6'($urandom_range(0, 59));
    it.now_fraction = wild ? 6'($urandom) : 6'($urandom_range(0, 49));
    return it;
  endfunction

  task automatic send_item(rrsp_pkg::item_t it);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, GapMax);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= it;
    do @(posedge clk_i); while (!s_axis_tready);
    mirror.note_item(it);
    if (!(it.action == ACT_UNUSED || (it.action == rrsp_pkg::ACT_SER_WRITE && it.port[0]))) begin
      sent_items++;
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (mirror.pending() > 0);
  endtask

  task automatic ser_write(logic [2:0] sel, logic lvl);
    send_item(make_item(rrsp_pkg::ACT_SER_WRITE, {7'($urandom), 1'b0},
                        {lvl, 4'($urandom), sel}));
  endtask

  task automatic ser_read();
    send_item(make_item(rrsp_pkg::ACT_SER_READ,
                        {7'($urandom), 1'($urandom_range(0, 7) != 0)}, 8'($urandom)));
  endtask

  task automatic clock_pulse();
    ser_write(rrsp_pkg::CTL_CLOCK, 1'b1);
    ser_write(rrsp_pkg::CTL_CLOCK, 1'b0);
  endtask

  task automatic serial_session();
    int unsigned pulses;
    ser_write(rrsp_pkg::CTL_SELECT, 1'b0);
    ser_write(rrsp_pkg::CTL_CLOCK, 1'b0);
    ser_write(rrsp_pkg::CTL_SELECT, 1'b1);
    repeat (4) begin
      ser_write(rrsp_pkg::CTL_DATA, 1'($urandom));
      if ($urandom_range(0, 1) == 0) ser_read();
      clock_pulse();
    end
    ser_write(rrsp_pkg::CTL_DATA, 1'b1);
    pulses = $urandom_range(1, 70);
    repeat (pulses) begin
      clock_pulse();
      ser_read();
      if ($urandom_range(0, 7) == 0) ser_write(rrsp_pkg::CTL_DATA, 1'($urandom));
      if ($urandom_range(0, 15) == 0) begin
        send_item(make_item(2'($urandom), 8'($urandom), 8'($urandom)));
      end
    end
    if ($urandom_range(0, 1) == 0) ser_write(rrsp_pkg::CTL_SELECT, 1'b0);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("retro_rtc_bus_and_serial_port_unit_test: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned stall;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = calm ? 0 : $urandom_range(0, GapMax);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      mirror.check_byte(m_axis_tdata);
    end
  end

  initial begin
    rrsp_pkg::item_t it;
    int unsigned     kind;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(make_item(rrsp_pkg::ACT_BUS_READ, rrsp_pkg::PORT_DATA, 8'h00));
    it = make_item(rrsp_pkg::ACT_BUS_READ, rrsp_pkg::PORT_LATCH, 8'hFF);
    it[63:18] = '1;
    send_item(it);
    repeat (rrsp_pkg::ByteCount + 1) begin
      send_item(make_item(rrsp_pkg::ACT_BUS_READ, rrsp_pkg::PORT_DATA, 8'($urandom)));
    end
    send_item(make_item(rrsp_pkg::ACT_BUS_READ, 8'd2, 8'h00));
    send_item(make_item(rrsp_pkg::ACT_BUS_READ, 8'hFF, 8'h00));
    it = make_item(rrsp_pkg::ACT_BUS_READ, rrsp_pkg::PORT_LATCH, 8'h00);
    it[63:18] = '0;
    send_item(it);
    send_item(make_item(rrsp_pkg::ACT_BUS_READ, rrsp_pkg::PORT_DATA, 8'h00));
    send_item(make_item(ACT_UNUSED, 8'h00, 8'hFF));
    send_item(make_item(rrsp_pkg::ACT_SER_READ, 8'hFE, 8'h00));
    send_item(make_item(rrsp_pkg::ACT_SER_READ, 8'h01, 8'h00));
    send_item(make_item(rrsp_pkg::ACT_SER_WRITE, 8'h01, {1'b1, 4'h0, rrsp_pkg::CTL_SELECT}));
    it = make_item(rrsp_pkg::ACT_SER_WRITE, 8'h00, {1'b1, 4'hF, rrsp_pkg::CTL_SELECT});
    it.now_century  = 7'd99;
    it.now_year     = 7'd99;
    it.now_month    = 4'd12;
    it.now_day      = 5'd31;
    it.now_hour     = 5'd23;
    it.now_minute   = 6'd59;
    it.now_second   = 6'd59;
    it.now_fraction = 6'd49;
    send_item(it);
    ser_write(rrsp_pkg::CTL_DATA, 1'b0);
    ser_read();
    ser_write(rrsp_pkg::CTL_DATA, 1'b1);
    ser_read();
    drain();

    while (sent_items < ItemGoal) begin
      calm = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        serial_session();
      end else if (kind < 75) begin
        send_item(make_item(rrsp_pkg::ACT_BUS_READ, rrsp_pkg::PORT_LATCH, 8'($urandom)));
        repeat ($urandom_range(1, 10)) begin
          send_item(make_item(rrsp_pkg::ACT_BUS_READ,
                              ($urandom_range(0, 9) == 0) ? 8'($urandom) : rrsp_pkg::PORT_DATA,
                              8'($urandom)));
        end
      end else begin
        repeat ($urandom_range(1, 8)) begin
          send_item(make_item(2'($urandom), 8'($urandom), 8'($urandom)));
        end
      end
      if ($urandom_range(0, 9) == 0) drain();
    end
    calm = 1'b0;
    drain();
    repeat (DrainCycles) @(posedge clk_i);

    $display("ran %0d counted items and checked %0d result bytes", sent_items, mirror.checked);
    $display("took %0d time latches, %0d bit pointer wraps, %0d mismatches",
             mirror.latches, mirror.wraps, mirror.errors);
    if (mirror.errors == 0 && mirror.pending() == 0) begin
      $display("retro_rtc_bus_and_serial_port_unit_test: done, clean");
    end else begin
      $display("retro_rtc_bus_and_serial_port_unit_test: done, errors");
    end
    $finish;
  end

endmodule

[retro_rtc_bus_and_serial_port_unit.f]
+incdir+sv
sv/rrsp_pkg.sv
sv/rrsp_core.sv
sv/retro_rtc_bus_and_serial_port_unit.sv
sv/rrsp_checker.sv
test/retro_rtc_bus_and_serial_port_unit_test.sv
